>>> hdl/char_lcd_nibble_writer_defines.svh
// ----------------------------------------------------------------------------
// Character-LCD nibble writer: assertion macros
// Shared macros for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cln_pkg.sv
// ----------------------------------------------------------------------------
// Character-LCD nibble writer: package
// Command codes, instruction bytes, the job record and the init sequence.
// ----------------------------------------------------------------------------
`default_nettype none

package cln_pkg;

  // Default wrap length for rows that are not four-row addressed.
  localparam int LineLengthDefault = 40;

  // Command codes.
  localparam logic [2:0] OpInit      = 3'd0;
  localparam logic [2:0] OpClear     = 3'd1;
  localparam logic [2:0] OpCursorOn  = 3'd2;
  localparam logic [2:0] OpCursorOff = 3'd3;
  localparam logic [2:0] OpGoto      = 3'd4;
  localparam logic [2:0] OpPut       = 3'd5;

  // Configuration register indexes.
  localparam logic [0:0] CfgRowCount    = 1'b0;
  localparam logic [0:0] CfgColumnCount = 1'b1;

  // Configuration reset values.
  localparam logic [2:0] RowCountReset    = 3'd2;
  localparam logic [5:0] ColumnCountReset = 6'd16;

  // Controller instruction bytes.
  localparam logic [7:0] CmdClear      = 8'h01;
  localparam logic [7:0] CmdEntryMode  = 8'h06;
  localparam logic [7:0] CmdDisplayOff = 8'h08;
  localparam logic [7:0] CmdCursorOff  = 8'h0C;
  localparam logic [7:0] CmdCursorOn   = 8'h0E;
  localparam logic [7:0] CmdFuncNarrow = 8'h20;
  localparam logic [7:0] CmdFuncWide   = 8'h28;
  localparam logic [7:0] CmdSetAddr    = 8'h80;
  localparam logic [6:0] RowOffset     = 7'h40;

  // Init emits one pass of fourteen nibbles twice.
  localparam logic [4:0] InitPass  = 5'd14;
  localparam logic [4:0] InitLast  = 5'd27;
  localparam logic [4:0] OneByteLast = 5'd1;
  localparam logic [4:0] TwoByteLast = 5'd3;

  // Depth of the queue between front and back.
  localparam int QueueDepth = 2;

  // One unit of work for the back end.
  typedef struct packed {
    logic       init;        // emit the init sequence
    logic       fs_wide;     // init uses the two-line function set
    logic       data_first;  // first byte goes to the data register
    logic       two;         // a second byte (instruction) follows
    logic [7:0] byte_a;
    logic [7:0] byte_b;
  } job_t;

  // Nibble at a given step of the init sequence.
  function automatic logic [3:0] init_nibble(input logic [4:0] step, input logic fs_wide);
    logic [4:0] pos;
    logic [7:0] fs;
    logic [3:0] n;
    pos = (step >= InitPass) ? step - InitPass : step;
    fs  = fs_wide ? CmdFuncWide : CmdFuncNarrow;
    unique case (pos)
      5'd0, 5'd1, 5'd2: n = 4'h3;
      5'd3:  n = 4'h2;
      5'd4:  n = fs[7:4];
      5'd5:  n = fs[3:0];
      5'd6:  n = CmdDisplayOff[7:4];
      5'd7:  n = CmdDisplayOff[3:0];
      5'd8:  n = CmdClear[7:4];
      5'd9:  n = CmdClear[3:0];
      5'd10: n = CmdEntryMode[7:4];
      5'd11: n = CmdEntryMode[3:0];
      5'd12: n = CmdCursorOff[7:4];
      5'd13: n = CmdCursorOff[3:0];
      default: n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cln_cmd_if.sv
// ----------------------------------------------------------------------------
// Character-LCD nibble writer: command channel
// Valid/ready channel carrying one display command per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cln_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] char_code;
  logic [5:0] target_column;
  logic [1:0] target_row;

  modport source (output valid, op, char_code, target_column, target_row, input ready);
  modport sink   (input valid, op, char_code, target_column, target_row, output ready);
endinterface

`default_nettype wire

>>> hdl/cln_nib_if.sv
// ----------------------------------------------------------------------------
// Character-LCD nibble writer: nibble channel
// Valid/ready channel carrying one bus nibble write per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cln_nib_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic       last;

  modport source (output valid, reg_select, nibble, last, input ready);
  modport sink   (input valid, reg_select, nibble, last, output ready);
endinterface

`default_nettype wire

>>> hdl/cln_cfg_if.sv
// ----------------------------------------------------------------------------
// Character-LCD nibble writer: configuration channel
// Valid/ready write channel with a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cln_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [5:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/cln_front.sv
// ----------------------------------------------------------------------------
// Character-LCD nibble writer: front end
// Holds configuration and the tracked cursor, turns each command into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module cln_front #(
  parameter int LINE_LENGTH = cln_pkg::LineLengthDefault
) (
  input  logic          clk,
  input  logic          rst,
  cln_cmd_if.sink       cmd,
  cln_cfg_if.sink       cfg,
  input  logic          q_ready,
  output logic          push,
  output cln_pkg::job_t push_job
);

  localparam logic [6:0] LineLen = 7'(LINE_LENGTH);

  logic [2:0] row_count;
  logic [5:0] column_count;
  logic [1:0] cursor_row;
  logic [5:0] cursor_column;

  logic       accept;
  logic       rows2;
  logic       rows4;
  logic [6:0] next_col;
  logic       put_goto;
  logic [5:0] g_col;
  logic [1:0] g_row;
  logic [6:0] offset;
  logic [6:0] addr;
  logic [7:0] goto_byte;

  assign cfg.ready = 1'b1;
  assign cmd.ready = q_ready;
  assign accept    = cmd.valid && q_ready;

  assign rows2    = (row_count == 3'd2);
  assign rows4    = (row_count == 3'd4);
  assign next_col = {1'b0, cursor_column} + 7'd1;

  // Goto target and whether a put needs to re-address the display.
  always_comb begin
    put_goto = 1'b0;
    g_col    = cmd.target_column;
    g_row    = cmd.target_row;
    if (cmd.op == cln_pkg::OpPut) begin
      if (rows4) begin
        put_goto = (next_col >= {1'b0, column_count});
        g_col    = 6'd0;
        g_row    = cursor_row + 2'd1;
      end else if (rows2) begin
        put_goto = (next_col >= LineLen);
        g_col    = 6'd0;
        g_row    = (cursor_row != 2'd0) ? 2'd0 : 2'd1;
      end else begin
        put_goto = 1'b1;
        g_col    = (next_col >= LineLen) ? 6'd0 : next_col[5:0];
        g_row    = cursor_row;
      end
    end
  end

  // Display-RAM address of the goto target.
  always_comb begin
    offset = 7'd0;
    if (rows2) begin
      offset = (g_row != 2'd0) ? cln_pkg::RowOffset : 7'd0;
    end else if (rows4) begin
      case (g_row)
        2'd1:    offset = cln_pkg::RowOffset;
        2'd2:    offset = {1'b0, column_count};
        2'd3:    offset = cln_pkg::RowOffset | {1'b0, column_count};
        default: offset = 7'd0;
      endcase
    end
    addr      = {1'b0, g_col} + offset;
    goto_byte = cln_pkg::CmdSetAddr | {1'b0, addr};
  end

  // Job record for the back end.
  always_comb begin
    push_job = '0;
    push     = 1'b0;
    unique case (cmd.op)
      cln_pkg::OpInit: begin
        push_job.init    = 1'b1;
        push_job.fs_wide = rows2 || rows4;
        push             = accept;
      end
      cln_pkg::OpClear: begin
        push_job.byte_a = cln_pkg::CmdClear;
        push            = accept;
      end
      cln_pkg::OpCursorOn: begin
        push_job.byte_a = cln_pkg::CmdCursorOn;
        push            = accept;
      end
      cln_pkg::OpCursorOff: begin
        push_job.byte_a = cln_pkg::CmdCursorOff;
        push            = accept;
      end
      cln_pkg::OpGoto: begin
        push_job.byte_a = goto_byte;
        push            = accept;
      end
      cln_pkg::OpPut: begin
        push_job.data_first = 1'b1;
        push_job.byte_a     = cmd.char_code;
        push_job.two        = put_goto;
        push_job.byte_b     = goto_byte;
        push                = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= cln_pkg::RowCountReset;
      column_count <= cln_pkg::ColumnCountReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        cln_pkg::CfgRowCount:    row_count    <= cfg.data[2:0];
        cln_pkg::CfgColumnCount: column_count <= cfg.data;
      endcase
    end
  end

  // Tracked cursor, updated when a command is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row    <= 2'd0;
      cursor_column <= 6'd0;
    end else if (accept) begin
      if (cmd.op == cln_pkg::OpInit) begin
        cursor_row    <= 2'd0;
        cursor_column <= 6'd0;
      end else if (cmd.op == cln_pkg::OpGoto || (cmd.op == cln_pkg::OpPut && put_goto)) begin
        cursor_row    <= g_row;
        cursor_column <= g_col;
      end else if (cmd.op == cln_pkg::OpPut) begin
        cursor_column <= next_col[5:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/cln_queue.sv
// ----------------------------------------------------------------------------
// Character-LCD nibble writer: job queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cln_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cln_pkg::job_t push_job,
  output logic          in_ready,
  output logic          q_valid,
  output cln_pkg::job_t q_job,
  input  logic          pop
);

  localparam int PtrW = (cln_pkg::QueueDepth > 1) ? $clog2(cln_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(cln_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(cln_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(cln_pkg::QueueDepth - 1);

  cln_pkg::job_t   slots [cln_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign in_ready = (count != Full);
  assign q_valid  = (count != '0);
  assign q_job    = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/cln_back.sv
// ----------------------------------------------------------------------------
// Character-LCD nibble writer: back end
// Steps through the current job and emits one nibble per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "char_lcd_nibble_writer_defines.svh"

module cln_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cln_pkg::job_t q_job,
  output logic          pop,
  cln_nib_if.source     nib
);

  cln_pkg::job_t cur;
  logic          have;
  logic [4:0]    idx;

  logic          advance;
  logic          last;
  logic          rs;
  logic [3:0]    nib_val;
  logic [7:0]    sel_byte;

  // The output register may be loaded when empty or being drained.
  assign advance = !nib.valid || nib.ready;

  // Nibble for the current step of the job.
  always_comb begin
    sel_byte = idx[1] ? cur.byte_b : cur.byte_a;
    if (cur.init) begin
      rs      = 1'b0;
      nib_val = cln_pkg::init_nibble(idx, cur.fs_wide);
      last    = (idx == cln_pkg::InitLast);
    end else begin
      rs      = cur.data_first && !idx[1];
      nib_val = idx[0] ? sel_byte[3:0] : sel_byte[7:4];
      last    = cur.two ? (idx == cln_pkg::TwoByteLast) : (idx == cln_pkg::OneByteLast);
    end
  end

  assign pop = q_valid && (!have || (advance && last));

  // Job sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      have      <= 1'b0;
      idx       <= 5'd0;
      nib.valid <= 1'b0;
    end else begin
      if (advance) begin
        nib.valid <= have;
      end
      if (have && advance && !last) begin
        idx <= idx + 5'd1;
      end else if (pop) begin
        have <= 1'b1;
        idx  <= 5'd0;
      end else if (have && advance && last) begin
        have <= 1'b0;
        idx  <= 5'd0;
      end
    end
  end

  // Current job record.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (advance && have) begin
      nib.reg_select <= rs;
      nib.nibble     <= nib_val;
      nib.last       <= last;
    end
  end

  `CLN_ASSERT_SAME(a_idle_idx_zero, clk, rst, !have, idx == 5'd0, "step count not clear while idle")
  `CLN_ASSERT_SAME(a_byte_job_len, clk, rst, have && !cur.init, idx <= cln_pkg::TwoByteLast, "byte job ran past its length")
  `CLN_ASSERT_SAME(a_init_len, clk, rst, have && cur.init, idx <= cln_pkg::InitLast, "init job ran past its length")
  `CLN_ASSERT_NEXT(a_pop_loads, clk, rst, pop, have && idx == 5'd0, "job taken from queue was not started")

endmodule

`default_nettype wire

>>> hdl/char_lcd_nibble_writer.sv
// ----------------------------------------------------------------------------
// Character-LCD nibble writer: top level
// Turns display commands into 4-bit bus writes for a character LCD.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - command transfers: init, clear, cursor on/off, goto, put character.
//   nib  - nibble transfers, high nibble first; reg_select marks data writes
//          and last marks the final nibble caused by a command.
//   cfg  - register writes: index 0 row count, index 1 column count. Write
//          only while no command is in flight.
// A command passes the job queue and current-job register before its first
// nibble is registered at the output. The back end emits one nibble per cycle
// while jobs wait and the receiver is ready: two nibbles for clear, cursor
// and goto, two or four for a put (four when the put re-addresses the
// display), 28 for init. Unknown codes are taken and dropped. A two-entry
// job queue lets commands be taken while earlier ones are still being written
// out. Reset clears the queue and output, sets row count 2, column count 16
// and the cursor to row 0, column 0. When the receiver stalls, the current
// nibble holds and the front keeps taking commands until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer #(
  parameter int LINE_LENGTH = cln_pkg::LineLengthDefault
) (
  input  logic      clk,
  input  logic      rst,
  cln_cmd_if.sink   cmd,
  cln_nib_if.source nib,
  cln_cfg_if.sink   cfg
);

  logic          push;
  cln_pkg::job_t push_job;
  logic          q_ready;
  logic          q_valid;
  cln_pkg::job_t q_job;
  logic          pop;

  // Command decode, configuration and cursor tracking.
  cln_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .q_ready (q_ready),
    .push    (push),
    .push_job(push_job)
  );

  // Job buffer between the two halves.
  cln_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .in_ready(q_ready),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop)
  );

  // Nibble sequencer and output register.
  cln_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_job  (q_job),
    .pop    (pop),
    .nib    (nib)
  );

endmodule

`default_nettype wire
